// ===== sv/assert_macros.svh =====
// Shared assertion macros. Every check runs on the rising edge of clock and
// is held off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

// When the trigger holds, the condition holds at the next clock edge.
`define ASSERT_NEXT(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("assertion failed");

`endif

// ===== sv/mgs_pkg.sv =====
package mgs_pkg;

   // Command codes carried by one input item.
   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_OPEN   = 3'd1,
      OP_CLOSE  = 3'd2,
      OP_START  = 3'd3,
      OP_CANCEL = 3'd4
   } op_type;

   // Move status codes.
   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_MOVING  = 3'd1,
      ST_REACHED = 3'd2,
      ST_NOMOVE  = 3'd3,
      ST_HALF    = 3'd4
   } status_type;

   // Self-test phases, one-hot.
   typedef enum logic [2:0] {
      PH_START = 3'b001,
      PH_OPEN  = 3'b010,
      PH_CLOSE = 3'b100
   } phase_type;

   localparam logic [1:0] FAULT_OPEN  = 2'b01;
   localparam logic [1:0] FAULT_CLOSE = 2'b10;
   localparam logic       DIR_OPEN    = 1'b0;
   localparam logic       DIR_CLOSE   = 1'b1;
   localparam logic [7:0] COUNT_MAX   = 8'hFF;
   localparam logic [3:0] RETRY_RESET = 4'd2;

   // Register address decode: one 32-bit register at byte address 0.
   localparam int unsigned ADDR_W  = 3;
   localparam logic        REG_LIM = 1'b0;

   // Sequencer state carried from one item to the next.
   typedef struct packed {
      logic       test_enable;
      phase_type  test_phase;
      logic       move_phase;
      logic [1:0] fault_flags;
      logic [7:0] open_failures;
      logic [7:0] close_failures;
   } state_type;

   // One input item.
   typedef struct packed {
      logic [2:0] operation;
      logic       limit_open;
      logic       limit_closed;
      logic       motor_running;
   } item_type;

   // One result item.
   typedef struct packed {
      logic       drive_start;
      logic       drive_direction;
      logic       drive_stop;
      logic [2:0] move_status;
      logic [1:0] fault_bits;
      logic       test_active;
      logic [7:0] open_fail_count;
      logic [7:0] close_fail_count;
   } result_type;

   localparam state_type STATE_RESET = '{
      test_enable:    1'b1,
      test_phase:     PH_START,
      move_phase:     1'b0,
      fault_flags:    2'b00,
      open_failures:  8'd0,
      close_failures: 8'd0
   };

   // Counter increment that stops at the top value.
   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v == COUNT_MAX) ? COUNT_MAX : v + 8'd1;
   endfunction

endpackage

// ===== sv/mgs_csr.sv =====
module mgs_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [mgs_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready,
   output logic [3:0]                   retry_limit
);
   import mgs_pkg::*;

   logic [3:0] retry_limit_ff;
   logic [3:0] retry_limit_in;
   logic       wr_hit;

   assign csr_pready = 1'b1;

   // A write transfer completes in the access cycle.
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[ADDR_W-1] == REG_LIM);

   assign retry_limit_in = wr_hit ? csr_pwdata[3:0] : retry_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= RETRY_RESET;
      end else begin
         retry_limit_ff <= retry_limit_in;
      end
   end

   // Reads return the limit at its address and zero elsewhere.
   assign csr_prdata = (csr_paddr[ADDR_W-1] == REG_LIM) ? {28'd0, retry_limit_ff} : 32'd0;
   assign retry_limit = retry_limit_ff;

endmodule

// ===== sv/mgs_step.sv =====
module mgs_step (
   input  mgs_pkg::state_type  cur,
   input  mgs_pkg::item_type   item,
   input  logic [3:0]          retry_limit,
   output mgs_pkg::state_type  nxt,
   output mgs_pkg::result_type res
);
   import mgs_pkg::*;

   logic       start;
   logic       dir;
   logic       stop;
   status_type status;
   logic       is_close;
   logic       at_target;
   logic       at_other;
   logic [1:0] move_mask;
   logic [7:0] close_inc;
   logic [7:0] limit_ext;

   assign limit_ext = {4'd0, retry_limit};
   assign close_inc = sat_inc(cur.close_failures);

   // The single move compares against the switch of its own target.
   assign is_close  = (item.operation == OP_CLOSE);
   assign at_target = is_close ? item.limit_closed : item.limit_open;
   assign at_other  = is_close ? item.limit_open : item.limit_closed;
   assign move_mask = is_close ? FAULT_CLOSE : FAULT_OPEN;

   always_comb begin
      nxt    = cur;
      start  = 1'b0;
      dir    = DIR_OPEN;
      stop   = 1'b0;
      status = ST_IDLE;
      case (item.operation)
         OP_TICK: begin
            if (!cur.test_enable) begin
               // A cancelled test stops the motor once, on the next tick.
               if (cur.test_phase != PH_START) begin
                  stop           = 1'b1;
                  nxt.test_phase = PH_START;
               end
            end else begin
               case (cur.test_phase)
                  PH_OPEN: begin
                     if (!item.motor_running) begin
                        if (item.limit_open) begin
                           nxt.fault_flags = cur.fault_flags & ~FAULT_OPEN;
                        end else begin
                           nxt.fault_flags   = cur.fault_flags | FAULT_OPEN;
                           nxt.open_failures = sat_inc(cur.open_failures);
                        end
                        nxt.test_phase = PH_CLOSE;
                        start          = 1'b1;
                        dir            = DIR_CLOSE;
                     end
                  end
                  PH_CLOSE: begin
                     if (!item.motor_running) begin
                        if (item.limit_closed) begin
                           // Closed: the test ends unless an open fault still
                           // has retries left.
                           nxt.test_phase = PH_START;
                           if (!((cur.fault_flags & FAULT_OPEN) != 2'b00
                                 && cur.open_failures < limit_ext)) begin
                              nxt.test_enable = 1'b0;
                           end
                           nxt.fault_flags = cur.fault_flags & ~FAULT_CLOSE;
                        end else begin
                           nxt.test_phase     = PH_OPEN;
                           nxt.fault_flags    = cur.fault_flags | FAULT_CLOSE;
                           nxt.close_failures = close_inc;
                           if (close_inc < limit_ext) begin
                              start = 1'b1;
                              dir   = DIR_OPEN;
                           end else begin
                              nxt.test_enable = 1'b0;
                              nxt.test_phase  = PH_START;
                           end
                        end
                     end
                  end
                  default: begin
                     // Start of a test round: move away from the current end.
                     start = 1'b1;
                     if (item.limit_open) begin
                        dir            = DIR_CLOSE;
                        nxt.test_phase = PH_CLOSE;
                     end else begin
                        dir            = DIR_OPEN;
                        nxt.test_phase = PH_OPEN;
                     end
                  end
               endcase
            end
         end
         OP_OPEN, OP_CLOSE: begin
            dir = is_close ? DIR_CLOSE : DIR_OPEN;
            if (!cur.move_phase) begin
               if (at_target) begin
                  status = ST_REACHED;
               end else begin
                  nxt.move_phase = 1'b1;
                  start          = 1'b1;
                  status         = ST_MOVING;
               end
            end else if (item.motor_running) begin
               status = ST_MOVING;
            end else begin
               nxt.move_phase = 1'b0;
               if (at_target) begin
                  nxt.fault_flags = cur.fault_flags & ~move_mask;
                  status          = ST_REACHED;
               end else begin
                  nxt.fault_flags = cur.fault_flags | move_mask;
                  status          = at_other ? ST_NOMOVE : ST_HALF;
               end
            end
         end
         OP_START: begin
            nxt.test_enable = 1'b1;
         end
         OP_CANCEL: begin
            nxt.test_enable = 1'b0;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   // Result fields show the state after the step.
   always_comb begin
      res.drive_start      = start;
      res.drive_direction  = start ? dir : DIR_OPEN;
      res.drive_stop       = stop;
      res.move_status      = status;
      res.fault_bits       = nxt.fault_flags;
      res.test_active      = nxt.test_enable;
      res.open_fail_count  = nxt.open_failures;
      res.close_fail_count = nxt.close_failures;
   end

endmodule

// ===== sv/motorized_gate_sequencer_top.sv =====
// Channel   Handshake            Payload
// req       req_valid/req_ready  operation, limit_open, limit_closed, motor_running
// rsp       rsp_valid/rsp_ready  drive and status fields, fault bits, fail counts
// csr       psel/penable/pwrite  retry_limit at byte address 0 (pready always high)
//
// An item waits in the input register; the step logic then updates the
// sequencer state and loads the result register at the same edge. Throughput
// is one item per cycle, set by the single state register update, while the
// result register is not stalled.
// Reset is synchronous and active high; it clears the state and both stages.
// A stalled result holds the input stage; new requests are taken while the
// input register is empty or moving on.
module motorized_gate_sequencer_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_operation,
   input  logic                        req_limit_open,
   input  logic                        req_limit_closed,
   input  logic                        req_motor_running,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_drive_start,
   output logic                        rsp_drive_direction,
   output logic                        rsp_drive_stop,
   output logic [2:0]                  rsp_move_status,
   output logic [1:0]                  rsp_fault_bits,
   output logic                        rsp_test_active,
   output logic [7:0]                  rsp_open_fail_count,
   output logic [7:0]                  rsp_close_fail_count,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [mgs_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import mgs_pkg::*;

`include "assert_macros.svh"

   logic [3:0] limit_val;

   logic       req_valid_ff;
   logic       req_valid_in;
   item_type   req_item_ff;
   item_type   req_item_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;
   result_type rsp_in;
   state_type  state_ff;
   state_type  state_in;
   state_type  state_nxt;
   result_type step_res;
   logic       advance;

   mgs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .retry_limit (limit_val)
   );

   mgs_step u_step (
      .cur         (state_ff),
      .item        (req_item_ff),
      .retry_limit (limit_val),
      .nxt         (state_nxt),
      .res         (step_res)
   );

   // The input stage moves on when the result register is free or draining.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_item_in  = req_item_ff;
      if (req_valid && req_ready) begin
         req_valid_in = 1'b1;
         req_item_in  = '{
            operation:     req_operation,
            limit_open:    req_limit_open,
            limit_closed:  req_limit_closed,
            motor_running: req_motor_running
         };
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   // State and result load together when an item leaves the input stage.
   always_comb begin
      state_in     = advance ? state_nxt : state_ff;
      rsp_in       = advance ? step_res : rsp_ff;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      req_item_ff <= req_item_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_drive_start      = rsp_ff.drive_start;
   assign rsp_drive_direction  = rsp_ff.drive_direction;
   assign rsp_drive_stop       = rsp_ff.drive_stop;
   assign rsp_move_status      = rsp_ff.move_status;
   assign rsp_fault_bits       = rsp_ff.fault_bits;
   assign rsp_test_active      = rsp_ff.test_active;
   assign rsp_open_fail_count  = rsp_ff.open_fail_count;
   assign rsp_close_fail_count = rsp_ff.close_fail_count;

   // The test phase register always holds exactly one phase.
   `ASSERT_ALWAYS(a_phase_onehot, $onehot(state_ff.test_phase))
   // A motor stop is only issued for a test that is no longer enabled.
   `ASSERT_ALWAYS(a_stop_disabled, !(rsp_valid_ff && rsp_ff.drive_stop) || !rsp_ff.test_active)
   // The failure counters never go down.
   `ASSERT_NEXT(a_open_mono, 1'b1, state_ff.open_failures >= $past(state_ff.open_failures))
   `ASSERT_NEXT(a_close_mono, 1'b1, state_ff.close_failures >= $past(state_ff.close_failures))
   // State only changes when an item is processed.
   `ASSERT_NEXT(a_state_hold, !advance, state_ff == $past(state_ff))

endmodule

// ===== tb/motorized_gate_sequencer_top_test.sv =====
module motorized_gate_sequencer_top_test;
   import mgs_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_STALL = 60;
   localparam int MAX_PRINTED = 100;
   localparam logic [ADDR_W-1:0] LIMIT_ADDR = ADDR_W'(4 * REG_LIM);

   logic clock;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_operation = '0;
   logic req_limit_open = 1'b0;
   logic req_limit_closed = 1'b0;
   logic req_motor_running = 1'b0;

   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_drive_start;
   logic rsp_drive_direction;
   logic rsp_drive_stop;
   logic [2:0] rsp_move_status;
   logic [1:0] rsp_fault_bits;
   logic rsp_test_active;
   logic [7:0] rsp_open_fail_count;
   logic [7:0] rsp_close_fail_count;

   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // Commands waiting to be offered, and gate results still owed by the block.
   item_type pending_commands[$];
   result_type expected_results[$];
   item_type offered_cmd;
   result_type oldest_result;

   // Shadow copy of the sequencer state and its retry limit.
   logic gate_enable = 1'b1;
   phase_type gate_phase = PH_START;
   logic move_active = 1'b0;
   logic [1:0] fault_state = 2'b00;
   logic [7:0] open_fails = 8'd0;
   logic [7:0] close_fails = 8'd0;
   logic [3:0] retry_limit_q = RETRY_RESET;

   int send_idle_max = 6;
   int recv_idle_max = 6;
   int send_gap = 0;
   int recv_stall = 0;
   int results_seen = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   motorized_gate_sequencer_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_limit_open(req_limit_open),
      .req_limit_closed(req_limit_closed),
      .req_motor_running(req_motor_running),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_drive_start(rsp_drive_start),
      .rsp_drive_direction(rsp_drive_direction),
      .rsp_drive_stop(rsp_drive_stop),
      .rsp_move_status(rsp_move_status),
      .rsp_fault_bits(rsp_fault_bits),
      .rsp_test_active(rsp_test_active),
      .rsp_open_fail_count(rsp_open_fail_count),
      .rsp_close_fail_count(rsp_close_fail_count),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED) begin
         $display("MISMATCH: %s", msg);
      end
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                   results_seen, name, got, want));
      end
   endtask

   // One step of a single open or close move; both directions share move_active.
   function automatic status_type move_step(input logic [1:0] fault_bit,
                                            input logic at_target, input logic at_other,
                                            input logic running, output logic started);
      started = 1'b0;
      if (!move_active) begin
         if (at_target) return ST_REACHED;
         move_active = 1'b1;
         started = 1'b1;
         return ST_MOVING;
      end
      if (running) return ST_MOVING;
      move_active = 1'b0;
      if (at_target) begin
         fault_state = fault_state & ~fault_bit;
         return ST_REACHED;
      end
      fault_state = fault_state | fault_bit;
      return at_other ? ST_NOMOVE : ST_HALF;
   endfunction

   // Advances the shadow state by one command and returns the gate result it owes.
   function automatic result_type gate_step(input item_type cmd);
      result_type r;
      logic lo, lc, run;
      logic start, dir, stop;
      status_type status;
      lo = cmd.limit_open;
      lc = cmd.limit_closed;
      run = cmd.motor_running;
      start = 1'b0;
      dir = DIR_OPEN;
      stop = 1'b0;
      status = ST_IDLE;
      case (cmd.operation)
         OP_TICK: begin
            if (!gate_enable) begin
               // A cancelled test is stopped on the next tick.
               if (gate_phase != PH_START) begin
                  stop = 1'b1;
                  gate_phase = PH_START;
               end
            end else if (gate_phase == PH_OPEN) begin
               if (!run) begin
                  if (lo) begin
                     fault_state = fault_state & ~FAULT_OPEN;
                  end else begin
                     fault_state = fault_state | FAULT_OPEN;
                     if (open_fails != COUNT_MAX) open_fails++;
                  end
                  gate_phase = PH_CLOSE;
                  start = 1'b1;
                  dir = DIR_CLOSE;
               end
            end else if (gate_phase == PH_CLOSE) begin
               if (!run) begin
                  if (lc) begin
                     // The test ends unless an open fault still has retries left.
                     if ((fault_state & FAULT_OPEN) == 2'b00 ||
                         open_fails >= {4'd0, retry_limit_q}) begin
                        gate_enable = 1'b0;
                     end
                     gate_phase = PH_START;
                     fault_state = fault_state & ~FAULT_CLOSE;
                  end else begin
                     fault_state = fault_state | FAULT_CLOSE;
                     if (close_fails != COUNT_MAX) close_fails++;
                     if (close_fails < {4'd0, retry_limit_q}) begin
                        gate_phase = PH_OPEN;
                        start = 1'b1;
                        dir = DIR_OPEN;
                     end else begin
                        gate_enable = 1'b0;
                        gate_phase = PH_START;
                     end
                  end
               end
            end else begin
               start = 1'b1;
               if (lo) begin
                  dir = DIR_CLOSE;
                  gate_phase = PH_CLOSE;
               end else begin
                  dir = DIR_OPEN;
                  gate_phase = PH_OPEN;
               end
            end
         end
         OP_OPEN: begin
            status = move_step(FAULT_OPEN, lo, lc, run, start);
            dir = DIR_OPEN;
         end
         OP_CLOSE: begin
            status = move_step(FAULT_CLOSE, lc, lo, run, start);
            dir = DIR_CLOSE;
         end
         OP_START: gate_enable = 1'b1;
         OP_CANCEL: gate_enable = 1'b0;
         default: ;
      endcase
      r.drive_start = start;
      r.drive_direction = start ? dir : DIR_OPEN;
      r.drive_stop = stop;
      r.move_status = status;
      r.fault_bits = fault_state;
      r.test_active = gate_enable;
      r.open_fail_count = open_fails;
      r.close_fail_count = close_fails;
      return r;
   endfunction

   // Driver: offers queued commands with a random gap after each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(gate_step(offered_cmd));
            send_gap = $urandom_range(0, send_idle_max);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_commands.size() != 0) begin
               offered_cmd = pending_commands.pop_front();
               req_operation <= offered_cmd.operation;
               req_limit_open <= offered_cmd.limit_open;
               req_limit_closed <= offered_cmd.limit_closed;
               req_motor_running <= offered_cmd.motor_running;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer against the oldest expectation and
   // throttles rsp_ready, with an occasional long hold-off to back up the block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         results_seen));
            end else begin
               oldest_result = expected_results.pop_front();
               compare_field("drive_start", rsp_drive_start, oldest_result.drive_start);
               compare_field("drive_direction", rsp_drive_direction,
                             oldest_result.drive_direction);
               compare_field("drive_stop", rsp_drive_stop, oldest_result.drive_stop);
               compare_field("move_status", rsp_move_status, oldest_result.move_status);
               compare_field("fault_bits", rsp_fault_bits, oldest_result.fault_bits);
               compare_field("test_active", rsp_test_active, oldest_result.test_active);
               compare_field("open_fail_count", rsp_open_fail_count,
                             oldest_result.open_fail_count);
               compare_field("close_fail_count", rsp_close_fail_count,
                             oldest_result.close_fail_count);
            end
            if (results_seen % 500 == 100) begin
               recv_stall = LONG_STALL;
            end else begin
               recv_stall = $urandom_range(0, recv_idle_max);
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_cmd(input logic [2:0] op, input logic lo, input logic lc,
                           input logic run);
      item_type c;
      c.operation = op;
      c.limit_open = lo;
      c.limit_closed = lc;
      c.motor_running = run;
      pending_commands.push_back(c);
   endtask

   // Register access over the APB-style port; a read is checked against the shadow.
   task automatic csr_access(input logic write, input logic [3:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= LIMIT_ADDR;
      csr_pwdata <= {28'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (!write && csr_prdata[3:0] !== retry_limit_q) begin
         report_mismatch($sformatf("retry_limit read back %0d, expected %0d",
                                   csr_prdata[3:0], retry_limit_q));
      end
      @(posedge clock);
      if (write) retry_limit_q = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Holds the sender back until every owed result has been seen.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_commands.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic start_phase(input logic [3:0] limit, input int send_max,
                              input int recv_max);
      wait_drained();
      csr_access(1'b1, limit);
      csr_access(1'b0, 4'd0);
      send_idle_max = send_max;
      recv_idle_max = recv_max;
   endtask

   // Mostly self-test sequences with random switch readings, plus single moves
   // and a little noise over all operation codes.
   task automatic add_random_traffic(input int target);
      int added, kind, n;
      logic [2:0] op;
      added = 0;
      while (added < target) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            if ($urandom_range(0, 3) != 0) begin
               push_cmd(OP_START, $urandom_range(0, 1), $urandom_range(0, 1),
                        $urandom_range(0, 1));
               added++;
            end
            n = $urandom_range(3, 8);
            repeat (n) begin
               op = ($urandom_range(0, 11) == 0) ? OP_CANCEL : OP_TICK;
               push_cmd(op, $urandom_range(0, 1), $urandom_range(0, 1),
                        $urandom_range(0, 3) == 0);
               added++;
            end
         end else if (kind < 9) begin
            op = $urandom_range(0, 1) ? OP_OPEN : OP_CLOSE;
            n = $urandom_range(2, 5);
            repeat (n) begin
               push_cmd(op, $urandom_range(0, 1), $urandom_range(0, 1),
                        $urandom_range(0, 2) == 0);
               added++;
            end
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               push_cmd($urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 1),
                        $urandom_range(0, 1));
               added++;
            end
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The retry limit must come out of reset at its documented value.
      csr_access(1'b0, 4'd0);

      // Self-test that passes on the first round.
      push_cmd(OP_TICK, 1'b0, 1'b1, 1'b0);
      push_cmd(OP_TICK, 1'b0, 1'b0, 1'b1);
      push_cmd(OP_TICK, 1'b1, 1'b0, 1'b0);
      push_cmd(OP_TICK, 1'b0, 1'b1, 1'b0);
      push_cmd(OP_TICK, 1'b0, 1'b0, 1'b0);
      // Restart from the open position: close fails, retry, open fails, retry.
      push_cmd(OP_START, 1'b0, 1'b0, 1'b0);
      push_cmd(OP_TICK, 1'b1, 1'b0, 1'b0);
      push_cmd(OP_TICK, 1'b0, 1'b0, 1'b0);
      push_cmd(OP_TICK, 1'b0, 1'b0, 1'b0);
      push_cmd(OP_TICK, 1'b0, 1'b1, 1'b0);
      // Cancel in the middle of a test, then the tick that stops the motor.
      push_cmd(OP_TICK, 1'b0, 1'b0, 1'b0);
      push_cmd(OP_CANCEL, 1'b1, 1'b1, 1'b1);
      push_cmd(OP_TICK, 1'b1, 1'b1, 1'b1);
      // Open moves: already there, moving, did not move, moving again.
      push_cmd(OP_OPEN, 1'b1, 1'b0, 1'b0);
      push_cmd(OP_OPEN, 1'b0, 1'b0, 1'b0);
      push_cmd(OP_OPEN, 1'b0, 1'b0, 1'b1);
      push_cmd(OP_OPEN, 1'b0, 1'b1, 1'b0);
      push_cmd(OP_OPEN, 1'b0, 1'b0, 1'b0);
      // A close step lands on the open move's shared phase.
      push_cmd(OP_CLOSE, 1'b0, 1'b1, 1'b0);
      push_cmd(OP_CLOSE, 1'b0, 1'b0, 1'b0);
      push_cmd(OP_CLOSE, 1'b0, 1'b0, 1'b0);
      push_cmd(OP_CLOSE, 1'b0, 1'b1, 1'b0);
      // Operation codes past cancel leave the state alone.
      for (int u = int'(OP_CANCEL) + 1; u < 8; u++) begin
         push_cmd(3'(u), 1'b1, 1'b1, 1'b1);
      end

      start_phase(4'd15, 0, 0);
      add_random_traffic(50);
      start_phase(4'd0, 6, 0);
      add_random_traffic(50);
      start_phase(4'd1, 0, 6);
      add_random_traffic(50);
      start_phase(4'($urandom_range(2, 14)), 6, 6);
      add_random_traffic(50);

      // Failing self-tests back to back drive both counters into saturation.
      start_phase(4'd1, 0, 6);
      repeat (270) begin
         push_cmd(OP_START, $urandom_range(0, 1), $urandom_range(0, 1),
                  $urandom_range(0, 1));
         push_cmd(OP_TICK, 1'b0, 1'b0, 1'b0);
         if ($urandom_range(0, 3) == 0) begin
            push_cmd(OP_TICK, $urandom_range(0, 1), $urandom_range(0, 1), 1'b1);
         end
         push_cmd(OP_TICK, 1'b0, 1'b0, 1'b0);
         if ($urandom_range(0, 3) == 0) begin
            push_cmd(OP_TICK, $urandom_range(0, 1), $urandom_range(0, 1), 1'b1);
         end
         push_cmd(OP_TICK, 1'b0, 1'b0, 1'b0);
      end

      start_phase(4'd15, 6, 6);
      add_random_traffic(50);

      wait_drained();
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
